/* design/flood_cycle_sequencer_unit_defines.svh */
// Assertion macros used by the flood cycle sequencer checker.
`ifndef FLOOD_CYCLE_SEQUENCER_UNIT_DEFINES_SVH
`define FLOOD_CYCLE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define FCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/fcs_pkg.sv */
// Types and constants of the flood cycle sequencer.
package fcs_pkg;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_FLOOD = 3'd1;
   localparam logic [2:0] PH_WAIT  = 3'd2;
   localparam logic [2:0] PH_FINAL = 3'd3;
   localparam logic [2:0] PH_DRAIN = 3'd4;
   localparam logic [2:0] PH_FAIL  = 3'd5;

   localparam logic [1:0] REG_PUMP_DRIVE      = 2'd0;
   localparam logic [1:0] REG_BOOST_DRIVE     = 2'd1;
   localparam logic [1:0] REG_WAIT_MINUTES    = 2'd2;
   localparam logic [1:0] REG_MIN_START_LEVEL = 2'd3;

   localparam logic [7:0]  RST_PUMP_DRIVE      = 8'd70;
   localparam logic [7:0]  RST_BOOST_DRIVE     = 8'd120;
   localparam logic [10:0] RST_WAIT_MINUTES    = 11'd1;
   localparam logic [7:0]  RST_MIN_START_LEVEL = 8'd128;

   localparam logic [7:0] MARGIN  = 8'h10;
   localparam logic [7:0] SAT_MAX = 8'hff;
   // reciprocals: x/3 = (x*171)>>9, x/5 = (x*205)>>10, exact for 8-bit x
   localparam logic [7:0] RECIP3  = 8'd171;
   localparam logic [7:0] RECIP5  = 8'd205;

   localparam logic [1:0] SPACING_STOP  = 2'd0;
   localparam logic [1:0] SPACING_ONE   = 2'd1;
   localparam logic [1:0] SPACING_THREE = 2'd3;

   typedef struct packed {
      logic [7:0]  pump_drive;
      logic [7:0]  boost_drive;
      logic [10:0] wait_minutes;
      logic [7:0]  min_start_level;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  level;
      logic [10:0] minute;
   } item_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  pump;
      logic        error_flag;
      logic [7:0]  start_level;
      logic [7:0]  top_volume;
      logic [7:0]  low_mark;
      logic [7:0]  low_stay;
      logic [7:0]  high_mark;
      logic [7:0]  high_stay;
      logic        siphon_seen;
      logic        wait_done;
      logic        long_delay;
      logic [10:0] wait_start;
   } state_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] pump_level;
      logic       dry_fault;
      logic [1:0] poll_spacing;
   } result_type;

endpackage

/* design/fcs_csr.sv */
// Configuration registers of the flood cycle sequencer.
module fcs_csr import fcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PUMP_DRIVE:      cfg_in.pump_drive      = csr_wdata[7:0];
            REG_BOOST_DRIVE:     cfg_in.boost_drive     = csr_wdata[7:0];
            REG_WAIT_MINUTES:    cfg_in.wait_minutes    = csr_wdata;
            REG_MIN_START_LEVEL: cfg_in.min_start_level = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pump_drive      <= RST_PUMP_DRIVE;
         cfg_ff.boost_drive     <= RST_BOOST_DRIVE;
         cfg_ff.wait_minutes    <= RST_WAIT_MINUTES;
         cfg_ff.min_start_level <= RST_MIN_START_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/fcs_step.sv */
// Next-state and result logic for one item of the flood cycle sequencer.
module fcs_step import fcs_pkg::*; (
   input  cfg_type    cfg,
   input  state_type  st,
   input  item_type   item,
   output state_type  st_next,
   output result_type res
);

   logic [7:0]  lm_n, ls_n, hm_n, hs_n;
   logic [15:0] tv_x3, tv_x5;
   logic [6:0]  tv_div3;
   logic [5:0]  tv_div5;
   logic [11:0] tv_x15;
   logic [7:0]  tv_15_16;
   logic        tv_nz;
   logic        siphon_hit, early_wait, wait_end, final_end, start_low;
   logic        polling;
   logic [1:0]  spacing;

   assign tv_nz    = (st.top_volume != 8'd0);
   assign tv_x3    = {8'd0, st.top_volume} * {8'd0, RECIP3};
   assign tv_x5    = {8'd0, st.top_volume} * {8'd0, RECIP5};
   assign tv_div3  = tv_x3[15:9];
   assign tv_div5  = tv_x5[15:10];
   assign tv_x15   = {st.top_volume, 4'd0} - {4'd0, st.top_volume};
   assign tv_15_16 = tv_x15[11:4];

   // running marks with saturating stay counters
   always_comb begin
      lm_n = st.low_mark;
      ls_n = st.low_stay;
      hm_n = st.high_mark;
      hs_n = st.high_stay;
      if (item.level < st.low_mark) begin
         lm_n = item.level;
         ls_n = 8'd0;
      end else if (st.low_stay < SAT_MAX) begin
         ls_n = st.low_stay + 8'd1;
      end
      if (item.level > st.high_mark) begin
         hm_n = item.level;
         hs_n = 8'd0;
      end else if (st.high_stay < SAT_MAX) begin
         hs_n = st.high_stay + 8'd1;
      end
   end

   assign siphon_hit = (ls_n > 8'd5) &&
      ((tv_nz && ({1'b0, item.level} + {2'b0, tv_div3} < {1'b0, st.start_level})) ||
       ({1'b0, item.level} + {1'b0, MARGIN} < {1'b0, st.start_level}));
   assign early_wait = !st.wait_done && tv_nz &&
      ({1'b0, item.level} + {1'b0, tv_15_16} <= {1'b0, st.start_level});
   assign wait_end   = {1'b0, item.minute} >=
      ({1'b0, st.wait_start} + {1'b0, cfg.wait_minutes});
   assign final_end  = {1'b0, item.level} > ({1'b0, lm_n} + {3'b0, tv_div5});
   assign start_low  = tv_nz ? ({1'b0, item.level} < ({1'b0, st.top_volume} + {1'b0, MARGIN}))
                             : (item.level < cfg.min_start_level);

   always_comb begin
      st_next = st;
      spacing = SPACING_STOP;
      polling = 1'b0;
      if (!item.kind) begin
         if (st.phase == PH_IDLE) begin
            if (start_low) begin
               st_next.phase      = PH_FAIL;
               st_next.error_flag = 1'b1;
            end else begin
               st_next.phase       = PH_FLOOD;
               st_next.start_level = item.level;
               st_next.wait_done   = 1'b0;
               st_next.siphon_seen = 1'b0;
               st_next.long_delay  = 1'b1;
               st_next.low_mark    = item.level;
               st_next.low_stay    = 8'd0;
               st_next.high_mark   = item.level;
               st_next.high_stay   = 8'd0;
               st_next.pump        = cfg.pump_drive;
               spacing             = SPACING_ONE;
            end
         end
      end else begin
         st_next.low_mark  = lm_n;
         st_next.low_stay  = ls_n;
         st_next.high_mark = hm_n;
         st_next.high_stay = hs_n;
         polling = 1'b1;
         case (st.phase)
            PH_FLOOD: begin
               if (siphon_hit) begin
                  st_next.siphon_seen = 1'b1;
                  st_next.top_volume  = st.start_level - lm_n;
                  if (st.wait_done) begin
                     st_next.phase      = PH_FINAL;
                     st_next.low_mark   = item.level;
                     st_next.low_stay   = 8'd0;
                     st_next.long_delay = 1'b1;
                     st_next.pump       = cfg.boost_drive;
                  end else begin
                     st_next.phase      = PH_WAIT;
                     st_next.wait_done  = 1'b1;
                     st_next.pump       = 8'd0;
                     st_next.wait_start = item.minute;
                  end
               end else if (early_wait) begin
                  st_next.phase      = PH_WAIT;
                  st_next.wait_done  = 1'b1;
                  st_next.pump       = 8'd0;
                  st_next.wait_start = item.minute;
               end
            end
            PH_WAIT: begin
               if (wait_end) begin
                  st_next.low_mark   = item.level;
                  st_next.low_stay   = 8'd0;
                  st_next.long_delay = 1'b1;
                  if (st.siphon_seen) begin
                     st_next.phase = PH_FINAL;
                     st_next.pump  = cfg.boost_drive;
                  end else begin
                     st_next.phase = PH_FLOOD;
                     st_next.pump  = cfg.pump_drive;
                  end
               end
            end
            PH_FINAL: begin
               if (final_end) begin
                  st_next.phase     = PH_DRAIN;
                  st_next.high_mark = item.level;
                  st_next.high_stay = 8'd0;
                  st_next.pump      = 8'd0;
               end
            end
            PH_DRAIN: begin
               if (hs_n > 8'd3) begin
                  st_next.phase = PH_IDLE;
                  polling       = 1'b0;
               end
            end
            default: polling = 1'b0;
         endcase
         if (polling) begin
            if (st_next.long_delay) begin
               st_next.long_delay = 1'b0;
               spacing            = SPACING_THREE;
            end else begin
               spacing = SPACING_ONE;
            end
         end
      end
   end

   assign res.phase        = st_next.phase;
   assign res.pump_level   = st_next.pump;
   assign res.dry_fault    = st_next.error_flag;
   assign res.poll_spacing = spacing;

endmodule

/* design/flood_cycle_sequencer_unit.sv */
// Flood cycle sequencer top level: input register, step logic, result register.
// A req transfer reaches rsp_tvalid through the input register, then the result register.
// Throughput: one item per cycle; state advances as an item moves into the result register.
// A stalled result holds the input register; the next item is taken once the result moves.
// Reset (synchronous, active high) empties both registers, clears state, loads csr defaults.
module flood_cycle_sequencer_unit import fcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // level[7:0], minute_of_day[18:8], zero[23:19]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // phase[2:0], pump_level[10:3], dry_fault[11],
                                    // poll_spacing[13:12], zero[15:14]
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_vld_ff, item_vld_in;
   state_type  state_ff, state_next;
   result_type res_ff, res_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;

   fcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fcs_step u_step (
      .cfg     (cfg),
      .st      (state_ff),
      .item    (item_ff),
      .st_next (state_next),
      .res     (res_in)
   );

   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || advance;

   always_comb begin
      item_in     = item_ff;
      item_vld_in = item_vld_ff && !advance;
      if (req_tvalid && req_tready) begin
         item_in.kind   = req_tuser;
         item_in.level  = req_tdata[7:0];
         item_in.minute = req_tdata[18:8];
         item_vld_in    = 1'b1;
      end
      rsp_vld_in = advance || (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         state_ff    <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (advance) state_ff <= state_next;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, res_ff.poll_spacing, res_ff.dry_fault,
                        res_ff.pump_level, res_ff.phase};

endmodule

/* design/fcs_checker.sv */
// Port-level checker for the flood cycle sequencer, bound to the top level.
`include "flood_cycle_sequencer_unit_defines.svh"

module fcs_checker import fcs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic [2:0] rsp_phase;
   logic [7:0] rsp_pump;
   logic       rsp_low;
   logic [1:0] rsp_spacing;

   assign rsp_phase   = rsp_tdata[2:0];
   assign rsp_pump    = rsp_tdata[10:3];
   assign rsp_low     = rsp_tdata[11];
   assign rsp_spacing = rsp_tdata[13:12];

   `FCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `FCS_ASSERT_NOW(a_low_in_fail, clock, reset, rsp_tvalid && rsp_low,
      rsp_phase == PH_FAIL, "low water flag outside failure")
   `FCS_ASSERT_NOW(a_rest_no_poll, clock, reset,
      rsp_tvalid && (rsp_phase == PH_IDLE || rsp_phase == PH_FAIL),
      rsp_spacing == SPACING_STOP, "polling requested while at rest")
   `FCS_ASSERT_NOW(a_pump_off, clock, reset,
      rsp_tvalid && (rsp_phase == PH_WAIT || rsp_phase == PH_DRAIN),
      rsp_pump == 8'd0, "pump driven during wait or drain")

endmodule

bind flood_cycle_sequencer_unit fcs_checker u_fcs_checker (.*);
